### sv/lfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PID steering package
// Shared widths, constants, register indexes and transaction types.
// ----------------------------------------------------------------------------
package lfps_pkg;

   localparam int DEFAULT_ACC_WIDTH    = 24;
   localparam int DEFAULT_OUTPUT_LIMIT = 100;

   localparam int BRIGHT_W    = 7;
   localparam int GAIN_W      = 16;
   localparam int ERR_W       = 8;
   localparam int DIFF_W      = 9;
   localparam int DIR_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [BRIGHT_W-1:0] TAIL_THRESHOLD = 7'd8;
   localparam logic [BRIGHT_W-1:0] DARK_LEVEL     = 7'd8;

   localparam logic [BRIGHT_W-1:0]      RST_LINE_THRESHOLD = 7'd8;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_P         = 16'sd2360;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_I         = 16'sd0;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_D         = 16'sd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_THRESHOLD = 2'd0,
      CSR_GAIN_P         = 2'd1,
      CSR_GAIN_I         = 2'd2,
      CSR_GAIN_D         = 2'd3
   } lfps_csr_type;

   typedef struct packed {
      logic                mode;
      logic [BRIGHT_W-1:0] brightness;
      logic                clear_on_line;
   } lfps_item_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic                     on_line;
   } lfps_err_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gp;
      logic signed [GAIN_W-1:0] gi;
      logic signed [GAIN_W-1:0] gd;
   } lfps_gains_type;

endpackage

### sv/lfps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PID steering channel interfaces
// Sample request channel and steering response channel, valid/ready.
// ----------------------------------------------------------------------------
interface lfps_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [lfps_pkg::BRIGHT_W-1:0]   brightness;
   logic                            clear_on_line;

   modport source (output valid, output mode, output brightness,
                   output clear_on_line, input ready);
   modport sink   (input valid, input mode, input brightness,
                   input clear_on_line, output ready);
endinterface

interface lfps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lfps_pkg::DIR_W-1:0]   direction;
   logic                                on_line;

   modport source (output valid, output direction, output on_line, input ready);
   modport sink   (input valid, input direction, input on_line, output ready);
endinterface

### sv/line_follow_pid_steering_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PID steering core
// Brightness sample in, clamped negated PID steering value and on-line flag out.
//
//   channel   direction   carries
//   req_if    in          mode, brightness, clear_on_line
//   rsp_if    out         direction, on_line
//   csr_*     in          line_threshold, three Q8.8 gains (write only)
//
// One transaction per cycle sustained while the response is not stalled;
// each sample passes four registers (input, error/integral, product, result)
// before its response is valid. The integral/previous-error feedback closes in
// the single error stage, one sample per cycle. Synchronous reset clears all
// valid flags and the controller state and loads register defaults. A stalled
// response holds each stage; bubbles are absorbed so input stays open.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_core #(
   parameter int ACC_WIDTH    = lfps_pkg::DEFAULT_ACC_WIDTH,
   parameter int OUTPUT_LIMIT = lfps_pkg::DEFAULT_OUTPUT_LIMIT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lfps_req_if.sink                             req_if,
   lfps_rsp_if.source                           rsp_if,
   input  logic                                 csr_write_enable,
   input  logic [lfps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import lfps_pkg::*;

   logic [BRIGHT_W-1:0]         line_threshold_ff;
   lfps_gains_type              gains_ff;

   logic                        in_ready;
   logic                        in_valid_ff;
   lfps_item_type               in_ff;

   logic                        trk_ready;
   logic                        trk_valid;
   lfps_err_type                trk_err;
   logic signed [ACC_WIDTH-1:0] trk_acc;
   logic                        mac_ready;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         line_threshold_ff <= RST_LINE_THRESHOLD;
         gains_ff.gp       <= RST_GAIN_P;
         gains_ff.gi       <= RST_GAIN_I;
         gains_ff.gd       <= RST_GAIN_D;
      end else if (csr_write_enable) begin
         unique case (lfps_csr_type'(csr_index))
            CSR_LINE_THRESHOLD: line_threshold_ff <= csr_write_data[BRIGHT_W-1:0];
            CSR_GAIN_P:         gains_ff.gp       <= $signed(csr_write_data);
            CSR_GAIN_I:         gains_ff.gi       <= $signed(csr_write_data);
            CSR_GAIN_D:         gains_ff.gd       <= $signed(csr_write_data);
         endcase
      end
   end

   // input register
   assign in_ready     = !in_valid_ff || trk_ready;
   assign req_if.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_if.valid) begin
         in_ff.mode          <= req_if.mode;
         in_ff.brightness    <= req_if.brightness;
         in_ff.clear_on_line <= req_if.clear_on_line;
      end
   end

   lfps_track #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (in_valid_ff),
      .in_ready       (trk_ready),
      .in_item        (in_ff),
      .line_threshold (line_threshold_ff),
      .out_valid      (trk_valid),
      .out_ready      (mac_ready),
      .out_err        (trk_err),
      .out_acc        (trk_acc)
   );

   lfps_mac #(
      .ACC_WIDTH    (ACC_WIDTH),
      .OUTPUT_LIMIT (OUTPUT_LIMIT)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (trk_valid),
      .in_ready      (mac_ready),
      .in_err        (trk_err),
      .in_acc        (trk_acc),
      .gains         (gains_ff),
      .out_valid     (rsp_if.valid),
      .out_ready     (rsp_if.ready),
      .out_direction (rsp_if.direction),
      .out_on_line   (rsp_if.on_line)
   );

endmodule

### sv/lfps_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PID error tracker
// Error, saturating trapezoidal integral, derivative step and on-line latch.
// ----------------------------------------------------------------------------
module lfps_track #(
   parameter int ACC_WIDTH = lfps_pkg::DEFAULT_ACC_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  lfps_pkg::lfps_item_type             in_item,
   input  logic [lfps_pkg::BRIGHT_W-1:0]       line_threshold,
   output logic                                out_valid,
   input  logic                                out_ready,
   output lfps_pkg::lfps_err_type              out_err,
   output logic signed [ACC_WIDTH-1:0]         out_acc
);
   import lfps_pkg::*;

   localparam int WIDE_W = ACC_WIDTH + 2;
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic                        fire;
   logic [BRIGHT_W-1:0]         thr;
   logic signed [ERR_W-1:0]     err_in;
   logic signed [DIFF_W-1:0]    diff_in;
   logic signed [WIDE_W-1:0]    acc_wide;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic                        latch_in;

   logic signed [ERR_W-1:0]     prev_err_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic                        latch_ff;
   logic                        valid_ff;
   lfps_err_type                err_ff;
   logic signed [ACC_WIDTH-1:0] acc_out_ff;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      thr      = in_item.mode ? line_threshold : TAIL_THRESHOLD;
      err_in   = $signed({1'b0, in_item.brightness}) - $signed({1'b0, thr});
      diff_in  = DIFF_W'(err_in) - DIFF_W'(prev_err_ff);
      acc_wide = WIDE_W'(acc_ff) + WIDE_W'(err_in) + WIDE_W'(prev_err_ff);
      if (acc_wide[WIDE_W-1:ACC_WIDTH-1] == '0 ||
          acc_wide[WIDE_W-1:ACC_WIDTH-1] == '1) begin
         acc_in = acc_wide[ACC_WIDTH-1:0];
      end else if (acc_wide[WIDE_W-1]) begin
         acc_in = ACC_MIN;
      end else begin
         acc_in = ACC_MAX;
      end
      latch_in = (in_item.clear_on_line ? 1'b0 : latch_ff) ||
                 (in_item.brightness < DARK_LEVEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         acc_ff      <= '0;
         latch_ff    <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (fire) begin
            prev_err_ff <= err_in;
            acc_ff      <= acc_in;
            latch_ff    <= latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         err_ff.err     <= err_in;
         err_ff.diff    <= diff_in;
         err_ff.on_line <= latch_in;
         acc_out_ff     <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_err   = err_ff;
   assign out_acc   = acc_out_ff;

endmodule

### sv/lfps_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PID product and output stage
// Three gain products, then sum, floor shift, negate and clamp.
// ----------------------------------------------------------------------------
module lfps_mac #(
   parameter int ACC_WIDTH    = lfps_pkg::DEFAULT_ACC_WIDTH,
   parameter int OUTPUT_LIMIT = lfps_pkg::DEFAULT_OUTPUT_LIMIT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  lfps_pkg::lfps_err_type              in_err,
   input  logic signed [ACC_WIDTH-1:0]         in_acc,
   input  lfps_pkg::lfps_gains_type            gains,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [lfps_pkg::DIR_W-1:0]   out_direction,
   output logic                                out_on_line
);
   import lfps_pkg::*;

   localparam int PP_W  = GAIN_W + ERR_W;
   localparam int PI_W  = GAIN_W + ACC_WIDTH;
   localparam int PD_W  = GAIN_W + DIFF_W;
   localparam int SUM_W = GAIN_W + ACC_WIDTH + 2;
   localparam int Q_W   = SUM_W - 8;
   localparam logic signed [Q_W-1:0]   LIM_Q   = Q_W'(OUTPUT_LIMIT);
   localparam logic signed [DIR_W-1:0] DIR_POS = DIR_W'(OUTPUT_LIMIT);
   localparam logic signed [DIR_W-1:0] DIR_NEG = DIR_W'(-OUTPUT_LIMIT);

   logic                     prod_adv;
   logic                     res_adv;
   logic signed [PP_W-1:0]   pp_in;
   logic signed [PI_W-1:0]   pi_in;
   logic signed [PD_W-1:0]   pd_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [Q_W-1:0]    q;
   logic signed [Q_W-1:0]    neg_q;
   logic signed [DIR_W-1:0]  dir_in;

   logic                     prod_valid_ff;
   logic signed [PP_W-1:0]   pp_ff;
   logic signed [PI_W-1:0]   pi_ff;
   logic signed [PD_W-1:0]   pd_ff;
   logic                     prod_on_line_ff;
   logic                     res_valid_ff;
   logic signed [DIR_W-1:0]  dir_ff;
   logic                     res_on_line_ff;

   assign res_adv  = !res_valid_ff || out_ready;
   assign prod_adv = !prod_valid_ff || res_adv;
   assign in_ready = prod_adv;

   always_comb begin
      pp_in = gains.gp * in_err.err;
      pi_in = gains.gi * in_acc;
      pd_in = gains.gd * in_err.diff;
   end

   always_comb begin
      sum   = SUM_W'(pp_ff) + SUM_W'(pi_ff) + SUM_W'(pd_ff);
      q     = sum[SUM_W-1:8];
      neg_q = -q;
      if (q > LIM_Q) begin
         dir_in = DIR_NEG;
      end else if (q < -LIM_Q) begin
         dir_in = DIR_POS;
      end else begin
         dir_in = neg_q[DIR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         if (prod_adv) begin
            prod_valid_ff <= in_valid;
         end
         if (res_adv) begin
            res_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_adv && in_valid) begin
         pp_ff           <= pp_in;
         pi_ff           <= pi_in;
         pd_ff           <= pd_in;
         prod_on_line_ff <= in_err.on_line;
      end
      if (res_adv && prod_valid_ff) begin
         dir_ff         <= dir_in;
         res_on_line_ff <= prod_on_line_ff;
      end
   end

   assign out_valid     = res_valid_ff;
   assign out_direction = dir_ff;
   assign out_on_line   = res_on_line_ff;

endmodule

### sv/lfps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PID steering checker
// Port-level checks on the response channel, bound to the core.
// ----------------------------------------------------------------------------
module lfps_checker #(
   parameter int OUTPUT_LIMIT = lfps_pkg::DEFAULT_OUTPUT_LIMIT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [lfps_pkg::DIR_W-1:0]   rsp_direction,
   input  logic                                rsp_on_line
);
   import lfps_pkg::*;

   localparam logic signed [DIR_W-1:0] LIM_POS = DIR_W'(OUTPUT_LIMIT);
   localparam logic signed [DIR_W-1:0] LIM_NEG = DIR_W'(-OUTPUT_LIMIT);

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_direction) && $stable(rsp_on_line))
      else $error("response payload changed while stalled");

   a_direction_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_direction <= LIM_POS) && (rsp_direction >= LIM_NEG))
      else $error("direction outside clamp limit");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind line_follow_pid_steering_core lfps_checker #(
   .OUTPUT_LIMIT (OUTPUT_LIMIT)
) u_lfps_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_direction (rsp_if.direction),
   .rsp_on_line   (rsp_if.on_line)
);
